// ----- src/frw_pkg.sv -----
// ---------------------------------------------------------------------------
// frw_pkg: shared types and constants of the frame reorder window
// store depth, derived widths, result status codes and sequencer states
// ---------------------------------------------------------------------------
package frw_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam int ID_W  = 32;
   localparam int TAG_W = 16;
   localparam int WIN_W = 16;

   localparam logic [WIN_W-1:0] SKIP_GAP_RESET = WIN_W'(8);

   typedef enum logic [1:0] {
      ST_RELEASED = 2'd0,
      ST_LATE     = 2'd1,
      ST_DUP      = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LATE,
      S_SCAN,
      S_INSERT,
      S_REL,
      S_SKIP,
      S_DONE
   } state_type;

endpackage

// ----- src/frame_reorder_window_top.sv -----
// ---------------------------------------------------------------------------
// frame_reorder_window_top: sequence-number reorder buffer
// sorted store of pending frames, released in order behind a window start
// ---------------------------------------------------------------------------
// usage
//   req_*  : one item per frame (32-bit sequence id, 16-bit payload tag)
//   rsp_*  : zero or more result items per request item; rsp_last marks the
//            final one, a request that only parks its frame gives none
//   csr_*  : writes the skip gap; taken only while the sequencer is idle
// flow
//   the ordered search walks the store entries in turn through the single
//   shared comparator, which then checks the store head for release; the
//   released frames leave one per cycle while no older staged result is
//   held back by a stalled receiver, and the window may skip ahead once
//   per item; req_ready is high only in the idle state, so items are handled
//   one at a time
// reset
//   synchronous, active high; store emptied (count 0), window start 0,
//   skip gap 8; store contents are not cleared
// stall
//   results pass through an output register; a stalled receiver holds the
//   sequencer before it stages the next result, no result is lost
// ---------------------------------------------------------------------------
module frame_reorder_window_top
   import frw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [ID_W-1:0]  req_frame_id,
   input  logic [TAG_W-1:0] req_payload_tag,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ID_W-1:0]  rsp_out_frame_id,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [WIN_W-1:0] csr_skip_gap
);

   // sequencer
   state_type        state_ff, state_in;

   // configuration and window
   logic [WIN_W-1:0] skip_gap_ff, skip_gap_in;
   logic [ID_W-1:0]  win_start_ff, win_start_in;

   // pending store, kept sorted ascending; entries at or above count are stale
   logic [ID_W-1:0]  pend_ids_ff  [STORE_DEPTH];
   logic [ID_W-1:0]  pend_ids_in  [STORE_DEPTH];
   logic [TAG_W-1:0] pend_tags_ff [STORE_DEPTH];
   logic [TAG_W-1:0] pend_tags_in [STORE_DEPTH];
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   // accepted item
   logic [ID_W-1:0]  in_id_ff, in_id_in;
   logic [TAG_W-1:0] in_tag_ff, in_tag_in;

   // search index, later the insert position
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             skip_done_ff, skip_done_in;

   // staged result, held back until we know whether it is the last one
   logic             res_valid_ff, res_valid_in;
   logic [ID_W-1:0]  res_id_ff, res_id_in;
   logic [TAG_W-1:0] res_tag_ff, res_tag_in;
   status_type       res_status_ff, res_status_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   // shared comparator, 33 bits so the skip bound never wraps
   logic [ID_W:0]    cmp_a, cmp_b;
   logic             cmp_eq, cmp_lt, cmp_gt;

   logic [ID_W-1:0]  scan_rd_id;
   logic             req_take;
   logic             out_free;
   logic             store_empty;
   logic             store_full;
   logic             scan_end;
   logic             rel_hit;
   logic             rel_go;
   logic             skip_hit;
   logic             do_insert;
   logic             do_pop;

   // ---------------- shared compare unit ----------------
   assign scan_rd_id = pend_ids_ff[idx_ff[IDX_W-1:0]];

   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         S_LATE: begin
            cmp_a = {1'b0, in_id_ff};
            cmp_b = {1'b0, win_start_ff};
         end
         S_SCAN: begin
            cmp_a = {1'b0, scan_rd_id};
            cmp_b = {1'b0, in_id_ff};
         end
         S_REL: begin
            cmp_a = {1'b0, pend_ids_ff[0]};
            cmp_b = {1'b0, win_start_ff};
         end
         S_SKIP: begin
            // window start plus tolerated gap, without wrap
            cmp_a = {1'b0, pend_ids_ff[0]};
            cmp_b = {1'b0, win_start_ff} + {{(ID_W+1-WIN_W){1'b0}}, skip_gap_ff};
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);
   assign cmp_gt = !cmp_eq && !cmp_lt;

   // ---------------- control terms ----------------
   assign req_take    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign store_empty = (pend_cnt_ff == '0);
   assign store_full  = (pend_cnt_ff == CNT_W'(STORE_DEPTH));
   assign scan_end    = (idx_ff == pend_cnt_ff);
   assign rel_hit     = !store_empty && cmp_eq;
   // a release waits only if an older staged result cannot leave yet
   assign rel_go      = rel_hit && (!res_valid_ff || out_free);
   assign skip_hit    = !store_empty && cmp_gt;
   assign do_insert   = (state_ff == S_INSERT);
   assign do_pop      = (state_ff == S_REL) && rel_go;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_LATE;
         end
         S_LATE: begin
            state_in = cmp_lt ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_end || cmp_gt) begin
               state_in = store_full ? S_DONE : S_INSERT;
            end else if (cmp_eq) begin
               state_in = S_DONE;
            end
         end
         S_INSERT: begin
            state_in = S_REL;
         end
         S_REL: begin
            if (!rel_hit) state_in = skip_done_ff ? S_DONE : S_SKIP;
         end
         S_SKIP: begin
            state_in = skip_hit ? S_REL : S_DONE;
         end
         S_DONE: begin
            if (!res_valid_ff || out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      skip_gap_in    = skip_gap_ff;
      win_start_in   = win_start_ff;
      in_id_in       = in_id_ff;
      in_tag_in      = in_tag_ff;
      idx_in         = idx_ff;
      skip_done_in   = skip_done_ff;
      res_valid_in   = res_valid_ff;
      res_id_in      = res_id_ff;
      res_tag_in     = res_tag_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_id_in      = rsp_id_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      req_ready      = (state_ff == S_IDLE);
      csr_ready      = (state_ff == S_IDLE);

      if (csr_valid && csr_ready) skip_gap_in = csr_skip_gap;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               in_id_in  = req_frame_id;
               in_tag_in = req_payload_tag;
            end
         end
         S_LATE: begin
            idx_in = '0;
            if (cmp_lt) begin
               res_valid_in  = 1'b1;
               res_id_in     = in_id_ff;
               res_tag_in    = in_tag_ff;
               res_status_in = ST_LATE;
            end
         end
         S_SCAN: begin
            if (scan_end || cmp_gt) begin
               // idx now holds the insert position
               if (store_full) begin
                  res_valid_in  = 1'b1;
                  res_id_in     = in_id_ff;
                  res_tag_in    = in_tag_ff;
                  res_status_in = ST_FULL;
               end
            end else if (cmp_eq) begin
               res_valid_in  = 1'b1;
               res_id_in     = in_id_ff;
               res_tag_in    = in_tag_ff;
               res_status_in = ST_DUP;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_INSERT: begin
            skip_done_in = 1'b0;
         end
         S_REL: begin
            if (rel_go) begin
               if (res_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = res_id_ff;
                  rsp_tag_in    = res_tag_ff;
                  rsp_status_in = res_status_ff;
                  rsp_last_in   = 1'b0;
               end
               res_valid_in  = 1'b1;
               res_id_in     = pend_ids_ff[0];
               res_tag_in    = pend_tags_ff[0];
               res_status_in = ST_RELEASED;
               win_start_in  = pend_ids_ff[0] + ID_W'(1);
            end
         end
         S_SKIP: begin
            skip_done_in = 1'b1;
            if (skip_hit) win_start_in = pend_ids_ff[0];
         end
         S_DONE: begin
            if (res_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_status_in = res_status_ff;
               rsp_last_in   = 1'b1;
               res_valid_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- store update: shift insert or pop head ----------------
   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         pend_ids_in[i]  = pend_ids_ff[i];
         pend_tags_in[i] = pend_tags_ff[i];
      end

      if (do_insert) begin
         pend_cnt_in = pend_cnt_ff + CNT_W'(1);
         if (idx_ff == '0) begin
            pend_ids_in[0]  = in_id_ff;
            pend_tags_in[0] = in_tag_ff;
         end
         for (int i = 1; i < STORE_DEPTH; i++) begin
            if (CNT_W'(i) == idx_ff) begin
               pend_ids_in[i]  = in_id_ff;
               pend_tags_in[i] = in_tag_ff;
            end else if (CNT_W'(i) > idx_ff) begin
               pend_ids_in[i]  = pend_ids_ff[i-1];
               pend_tags_in[i] = pend_tags_ff[i-1];
            end
         end
      end else if (do_pop) begin
         pend_cnt_in = pend_cnt_ff - CNT_W'(1);
         for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            pend_ids_in[i]  = pend_ids_ff[i+1];
            pend_tags_in[i] = pend_tags_ff[i+1];
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         skip_gap_ff    <= SKIP_GAP_RESET;
         win_start_ff   <= '0;
         pend_cnt_ff    <= '0;
         skip_done_ff   <= 1'b0;
         res_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         skip_gap_ff    <= skip_gap_in;
         win_start_ff   <= win_start_in;
         pend_cnt_ff    <= pend_cnt_in;
         skip_done_ff   <= skip_done_in;
         res_valid_ff   <= res_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_id_ff      <= in_id_in;
      in_tag_ff     <= in_tag_in;
      idx_ff        <= idx_in;
      res_id_ff     <= res_id_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         pend_ids_ff[i]  <= pend_ids_in[i];
         pend_tags_ff[i] <= pend_tags_in[i];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_frame_id = rsp_id_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------- assertions ----------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= CNT_W'(STORE_DEPTH))
      else $error("pending count above store depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= pend_cnt_ff))
      else $error("search index past pending count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff >= CNT_W'(2)) |-> (pend_ids_ff[0] < pend_ids_ff[1]))
      else $error("store head out of order");

   a_take_clean: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !res_valid_ff)
      else $error("new item taken while a result is still staged");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      do_insert |-> !store_full)
      else $error("insert into a full store");

endmodule

// ----- tb/frame_reorder_window_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_reorder_window_top_tb: self-checking bench of the frame reorder window
// a behavioral model of the sorted store predicts the released and dropped
// frames of every accepted item; a monitor compares each result in order
// ---------------------------------------------------------------------------
module frame_reorder_window_top_tb;
   import frw_pkg::*;

   // settle time, well above the longest item, which releases the whole store
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [TAG_W-1:0] tag;
      status_type       status;
      logic             last;
   } frame_outcome_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;

   logic             req_valid       = 1'b0;
   logic             req_ready;
   logic [ID_W-1:0]  req_frame_id    = '0;
   logic [TAG_W-1:0] req_payload_tag = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [ID_W-1:0]  rsp_out_frame_id;
   logic [TAG_W-1:0] rsp_out_tag;
   logic [1:0]       rsp_status;
   logic             rsp_last;

   logic             csr_valid    = 1'b0;
   logic             csr_ready;
   logic [WIN_W-1:0] csr_skip_gap = '0;

   // model of the block: sorted pending store, window start, skip gap
   logic [ID_W-1:0]  frame_ids  [STORE_DEPTH];
   logic [TAG_W-1:0] frame_tags [STORE_DEPTH];
   int               held_count       = 0;
   logic [ID_W-1:0]  next_expected_id = '0;
   logic [WIN_W-1:0] gap_limit        = SKIP_GAP_RESET;

   // frame outcomes still owed by the block, oldest first
   frame_outcome_type outcome_q[$];

   int errors          = 0;
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_cycles     = 0;

   always #6 clock = ~clock;

   frame_reorder_window_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_id     (req_frame_id),
      .req_payload_tag  (req_payload_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_frame_id (rsp_out_frame_id),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_skip_gap     (csr_skip_gap)
   );

   // ------------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------------
   function automatic void push_outcome(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                                        status_type st, logic fin);
      frame_outcome_type o;
      o.id     = id;
      o.tag    = tag;
      o.status = st;
      o.last   = fin;
      outcome_q.push_back(o);
   endfunction

   // release every head frame that matches the window start
   function automatic int release_in_order();
      int n;
      n = 0;
      while (held_count > 0 && frame_ids[0] == next_expected_id) begin
         push_outcome(frame_ids[0], frame_tags[0], ST_RELEASED, 1'b0);
         next_expected_id = frame_ids[0] + 32'd1;   // wraps past all ones
         for (int i = 1; i < held_count; i++) begin
            frame_ids[i-1]  = frame_ids[i];
            frame_tags[i-1] = frame_tags[i];
         end
         held_count--;
         n++;
      end
      return n;
   endfunction

   function automatic void predict_frame(logic [ID_W-1:0] id, logic [TAG_W-1:0] tag);
      int                pos;
      int                n;
      frame_outcome_type tail;
      // drop checks in priority order: late, duplicate, store full
      if (id < next_expected_id) begin
         push_outcome(id, tag, ST_LATE, 1'b1);
         return;
      end
      for (int i = 0; i < held_count; i++) begin
         if (frame_ids[i] == id) begin
            push_outcome(id, tag, ST_DUP, 1'b1);
            return;
         end
      end
      if (held_count >= STORE_DEPTH) begin
         push_outcome(id, tag, ST_FULL, 1'b1);
         return;
      end
      // sorted insert
      pos = 0;
      while (pos < held_count && frame_ids[pos] < id) pos++;
      for (int i = held_count; i > pos; i--) begin
         frame_ids[i]  = frame_ids[i-1];
         frame_tags[i] = frame_tags[i-1];
      end
      frame_ids[pos]  = id;
      frame_tags[pos] = tag;
      held_count++;
      n = release_in_order();
      // skip test is done at 33 bits, no wrap of the window end
      if (held_count > 0 &&
          {1'b0, frame_ids[0]} > {1'b0, next_expected_id} + {17'd0, gap_limit}) begin
         next_expected_id = frame_ids[0];
         n += release_in_order();
      end
      if (n > 0) begin
         tail      = outcome_q.pop_back();
         tail.last = 1'b1;
         outcome_q.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------------
   // result monitor and receiver ready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_outcome_type got;
      frame_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.id     = rsp_out_frame_id;
         got.tag    = rsp_out_tag;
         got.status = status_type'(rsp_status);
         got.last   = rsp_last;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result: id %h tag %h status %0d last %b",
                     $time, got.id, got.tag, got.status, got.last);
            errors++;
         end else begin
            want = outcome_q[0];
            outcome_q.delete(0);
            if (got.id !== want.id || got.tag !== want.tag ||
                got.status !== want.status || got.last !== want.last) begin
               $display("%0t: mismatch: expected id %h tag %h status %0d last %b",
                        $time, want.id, want.tag, want.status, want.last);
               $display("%0t:           actual   id %h tag %h status %0d last %b",
                        $time, got.id, got.tag, got.status, got.last);
               errors++;
            end
         end
      end
      // a long hold-off is counted here, independent of the sender
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // shared driving tasks
   // ------------------------------------------------------------------------
   // offer one frame, optionally after a random gap, and model it on acceptance
   task automatic send_frame(input logic [ID_W-1:0] id, input logic [TAG_W-1:0] tag);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_id    <= id;
      req_payload_tag <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frame(id, tag);
   endtask

   // sender pause: nothing offered until every owed result has come
   task automatic wait_for_outcomes();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcome_q.size() != 0);
   endtask

   // register write only with the block idle; a parked frame gives no result,
   // so wait the settle time after the last one for the sequencer to go idle
   task automatic set_skip_gap(input logic [WIN_W-1:0] value);
      wait_for_outcomes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_skip_gap <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gap_limit = value;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      stall_pct       = receiver_pct;
   endtask

   // fill the gap at the window start until the store empties
   task automatic drain_store();
      int guard;
      guard = 0;
      while (held_count > 0 && guard < 100) begin
         send_frame(next_expected_id, TAG_W'($urandom));
         guard++;
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset skip gap of 8: in-order release, late, duplicate, parking
   task automatic test_in_order_delivery();
      set_idling(0, 0);
      send_frame(32'd0, 16'h0000);      // released, window to 1
      send_frame(32'd0, 16'hFFFF);      // late
      send_frame(32'd3, 16'h1234);      // parked, no result
      send_frame(32'd3, 16'h5555);      // duplicate of a pending id
      send_frame(32'd2, 16'h8001);      // parked
      send_frame(32'd1, 16'h7FFE);      // releases 1, 2, 3
   endtask

   // window skip, wrap of the window start, skip gap extremes and the
   // unwrapped window end near the top of the id range
   task automatic test_window_skip();
      set_idling(0, 0);
      send_frame(32'd20, 16'hC3C3);         // gap beyond 8: skip, release 20
      send_frame(32'hFFFF_FFFF, 16'hAAAA);  // skip to all ones, window wraps to 0
      send_frame(32'd0, 16'h0F0F);          // released after the wrap
      set_skip_gap(16'h0000);
      send_frame(32'd3, 16'h3C3C);          // any gap skips with a zero window
      set_skip_gap(16'hFFFF);
      send_frame(32'hFFFF_FFF0, 16'h0001);  // skip, window to ...F1
      send_frame(32'hFFFF_FFFE, 16'h0002);  // parked
      send_frame(32'hFFFF_FFFF, 16'h0003);  // parked
      send_frame(32'hFFFF_FFF1, 16'h0004);  // one release, window end past 2^32
      set_skip_gap(16'h0003);
      send_frame(32'hFFFF_FFF3, 16'h0005);  // parked, within the window
      send_frame(32'hFFFF_FFF2, 16'h0006);  // two releases, skip, two more
   endtask

   // mostly short shuffled runs of consecutive ids, some with a hole, mixed
   // with late, duplicate, far and near-window frames
   task automatic run_mixed_traffic(input int n_items);
      int              sent;
      int              kind;
      int              len;
      int              hole;
      int              k;
      logic [ID_W-1:0] base;
      logic [ID_W-1:0] swap;
      logic [ID_W-1:0] run_ids [6];
      sent = 0;
      while (sent < n_items) begin
         // keep the store from filling: a full store can never drain
         if (held_count >= 10) drain_store();
         kind = $urandom_range(99);
         if (kind < 60) begin
            len  = $urandom_range(6, 1);
            base = next_expected_id + $urandom_range(2, 0);
            for (int j = 0; j < len; j++) run_ids[j] = base + j;
            for (int j = len - 1; j > 0; j--) begin
               k          = $urandom_range(j, 0);
               swap       = run_ids[j];
               run_ids[j] = run_ids[k];
               run_ids[k] = swap;
            end
            hole = ($urandom_range(3) == 0) ? $urandom_range(len - 1, 0) : -1;
            for (int j = 0; j < len; j++) begin
               if (j != hole) begin
                  send_frame(run_ids[j], TAG_W'($urandom));
                  sent++;
               end
            end
         end else if (kind < 70 && next_expected_id != 0) begin
            send_frame($urandom_range(next_expected_id - 32'd1, 0), TAG_W'($urandom));
            sent++;
         end else if (kind < 80 && held_count > 0) begin
            send_frame(frame_ids[$urandom_range(held_count - 1, 0)], TAG_W'($urandom));
            sent++;
         end else if (kind < 90) begin
            send_frame($urandom, TAG_W'($urandom));
            sent++;
         end else begin
            send_frame(next_expected_id + $urandom_range(20, 0), TAG_W'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_mixed_traffic();
      set_idling(0, 0);
      set_skip_gap(16'd8);
      run_mixed_traffic(80);
      set_idling(84, 0);
      set_skip_gap(16'h0000);
      run_mixed_traffic(80);
      set_idling(0, 84);
      set_skip_gap(16'hFFFF);
      run_mixed_traffic(80);
      set_idling(23, 23);
      set_skip_gap(WIN_W'($urandom_range(64, 1)));
      run_mixed_traffic(80);
      set_idling(0, 0);
      set_skip_gap(WIN_W'($urandom));
      run_mixed_traffic(80);
   endtask

   // receiver holds off while the sender keeps offering, then a full pause
   task automatic test_backpressure();
      logic [ID_W-1:0] base;
      set_idling(0, 0);
      drain_store();
      wait_for_outcomes();
      hold_cycles = 300;
      base = next_expected_id;
      for (int j = 0; j < 8; j++) send_frame(base + j, TAG_W'($urandom));
      base = next_expected_id;
      for (int j = 3; j >= 0; j--) send_frame(base + j, TAG_W'($urandom));  // burst of four
      wait_for_outcomes();
      base = next_expected_id;
      send_frame(base + 1, TAG_W'($urandom));
      send_frame(base, TAG_W'($urandom));
   endtask

   // store full is terminal: nothing can be inserted to drain it, so last
   task automatic test_store_full();
      logic [ID_W-1:0] base;
      logic [ID_W-1:0] swap;
      logic [ID_W-1:0] fill_ids [STORE_DEPTH];
      int              k;
      set_idling(0, 0);
      set_skip_gap(16'hFFFF);
      drain_store();
      base = next_expected_id;
      for (int j = 0; j < STORE_DEPTH; j++) fill_ids[j] = base + j + 1;
      for (int j = STORE_DEPTH - 1; j > 0; j--) begin
         k           = $urandom_range(j, 0);
         swap        = fill_ids[j];
         fill_ids[j] = fill_ids[k];
         fill_ids[k] = swap;
      end
      for (int j = 0; j < STORE_DEPTH; j++) send_frame(fill_ids[j], TAG_W'($urandom));
      send_frame(base + 20, 16'hFFFF);   // store full
      send_frame(base + 5, 16'h0000);    // duplicate wins over full
      if (base != 0) send_frame(base - 1, 16'hA5A5);  // late wins over full
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      int cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_in_order_delivery();
      test_window_skip();
      test_mixed_traffic();
      test_backpressure();
      test_store_full();
      // drain what is still owed, then let the sequencer settle
      req_valid <= 1'b0;
      cycles = 0;
      do begin
         @(posedge clock);
         cycles++;
      end while (outcome_q.size() != 0 && cycles < 100000);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived, oldest id %h",
                  $time, outcome_q.size(), outcome_q[0].id);
         errors++;
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hard limit on the whole run
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
